>>> hw/rtl/evfe_pkg.sv
package evfe_pkg;

	localparam int MUL_W = 32;
	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_DIMENSION = 1'b0;
	localparam logic [3:0] DIM_RESET = 4'd8;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_ZERO_VEC = 2'd1,
		STATUS_INDEX = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_VACC,
		ST_Y,
		ST_YLO,
		ST_YMID,
		ST_YHI,
		ST_YEND,
		ST_CHK,
		ST_ROOT,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		RT_IDLE,
		RT_DIV,
		RT_SQRT,
		RT_DONE
	} root_state_t;

	typedef struct packed {
		logic done;
		logic sat;
	} root_rsp_t;

endpackage

>>> hw/rtl/evfe_in_if.sv
interface evfe_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [2:0]  row_index;
	logic [2:0]  col_index;
	logic [31:0] entry_value;
	logic        last_item;

	modport source (
		output valid, req_type, row_index, col_index, entry_value, last_item,
		input  ready
	);
	modport sink (
		input  valid, req_type, row_index, col_index, entry_value, last_item,
		output ready
	);
endinterface

>>> hw/rtl/evfe_out_if.sv
interface evfe_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] eigenvalue;
	logic [1:0]  status;

	modport source (
		output valid, eigenvalue, status,
		input  ready
	);
	modport sink (
		input  valid, eigenvalue, status,
		output ready
	);
endinterface

>>> hw/rtl/evfe_mul.sv
module evfe_mul import evfe_pkg::*; (
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   p
);

	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

>>> hw/rtl/evfe_root.sv
module evfe_root import evfe_pkg::*; #(
	parameter int EW  = 32,
	parameter int S1W = 68,
	parameter int S2W = 108
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [S1W-1:0]  s1,
	input  logic [S2W-1:0]  s2,
	output root_rsp_t       rsp,
	output logic [EW-2:0]   root
);

	localparam int NB   = S2W + 32;
	localparam int QW   = 2 * EW - 2;
	localparam int RW   = EW - 1;
	localparam int DIVW = S1W + 1;
	localparam int SQW  = RW + 3;
	localparam int SW   = (DIVW > SQW) ? DIVW : SQW;
	localparam int NCW  = $clog2(NB + 1);

	root_state_t state_q, state_d;

	logic [NB-1:0]  sh_q;
	logic [S1W-1:0] drem_q;
	logic [QW:0]    dq_q;
	logic [QW-1:0]  sq_q;
	logic [RW:0]    srem_q;
	logic [RW-1:0]  root_q;
	logic [NCW-1:0] cnt_q;
	logic           sat_q;

	logic [DIVW-1:0] a_div;
	logic [SQW-1:0]  a_sq;
	logic [SW-1:0]   a_op, b_op;
	logic [SW:0]     diff;
	logic            ge;
	logic [QW:0]     dq_next;
	logic            cnt_last;

	// one compare-subtract serves both the divide and the root
	assign a_div = {drem_q, sh_q[NB-1]};
	assign a_sq  = {srem_q, sq_q[QW-1:QW-2]};
	assign a_op  = (state_q == RT_SQRT) ? SW'(a_sq) : SW'(a_div);
	assign b_op  = (state_q == RT_SQRT) ? SW'({root_q, 2'b01}) : SW'(s1);
	assign diff  = {1'b0, a_op} - {1'b0, b_op};
	assign ge    = ~diff[SW];
	assign dq_next  = {dq_q[QW-1:0], ge};
	assign cnt_last = (cnt_q == NCW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			RT_IDLE: begin
				if (start) state_d = RT_DIV;
			end
			RT_DIV: begin
				if (dq_next[QW]) state_d = RT_DONE;
				else if (cnt_last) state_d = RT_SQRT;
			end
			RT_SQRT: begin
				if (cnt_last) state_d = RT_DONE;
			end
			RT_DONE: state_d = RT_IDLE;
			default: state_d = RT_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			RT_IDLE: begin
				if (start) begin
					sh_q   <= {s2, 32'b0};
					drem_q <= '0;
					dq_q   <= '0;
					cnt_q  <= NCW'(NB);
					sat_q  <= 1'b0;
				end
			end
			RT_DIV: begin
				sh_q   <= {sh_q[NB-2:0], 1'b0};
				drem_q <= ge ? diff[S1W-1:0] : a_div[S1W-1:0];
				dq_q   <= dq_next;
				cnt_q  <= cnt_q - NCW'(1);
				if (dq_next[QW]) begin
					sat_q <= 1'b1;
				end else if (cnt_last) begin
					sq_q   <= dq_next[QW-1:0];
					srem_q <= '0;
					root_q <= '0;
					cnt_q  <= NCW'(RW);
				end
			end
			RT_SQRT: begin
				srem_q <= ge ? diff[RW:0] : a_sq[RW:0];
				root_q <= {root_q[RW-2:0], ge};
				sq_q   <= {sq_q[QW-3:0], 2'b00};
				cnt_q  <= cnt_q - NCW'(1);
			end
			default: ;
		endcase
	end

	assign rsp.done = (state_q == RT_DONE);
	assign rsp.sat  = sat_q;
	assign root     = root_q;

endmodule

>>> hw/rtl/eigenvalue_from_eigenvector.sv
// Load words: one per cycle while idle; a word not flagged last gives no result.
// Last word: the result comes from the shared 32x32 multiplier and the
// one-bit-per-cycle divide/root unit.
// No word is taken from the last word until its result is registered.
// Async reset clears control and the index error, dimension returns to 8; stores are not cleared.
module eigenvalue_from_eigenvector import evfe_pkg::*; #(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	evfe_in_if.sink            item,
	evfe_out_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int EW  = (VALUE_WIDTH < 16) ? 16 : ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);
	localparam int DW  = $clog2(MAX_DIM + 1);
	localparam int DCW = (DW > 4) ? DW : 4;
	localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
	localparam int ACW = 2 * EW + DW;
	localparam int YW  = ACW - 16;
	localparam int S1W = 2 * EW + DW;
	localparam int S2W = 2 * YW + DW;

	seq_state_t state_q, state_d;

	logic [EW-1:0] mat_mem [MAX_DIM*MAX_DIM];
	logic [EW-1:0] vec_mem [MAX_DIM];

	logic [3:0]     dim_q;
	logic           err_q;
	logic [IW-1:0]  i_q, j_q;
	logic [EW-1:0]  a_rd_q, v_rd_q;
	logic           psign_q;
	logic [ACW-1:0] acc_q;
	logic [S1W-1:0] s1_q;
	logic [S2W-1:0] s2_q;
	logic [YW-1:0]  ymag_q;
	logic           v0neg_q, v0nz_q, y0neg_q, y0nz_q;
	logic [31:0]    res_eig_q;
	status_t        res_status_q;
	logic           out_valid_q;
	logic [31:0]    out_eig_q;
	status_t        out_status_q;

	logic [DCW-1:0]     d_used;
	logic               in_acc, in_bad, row_ok, col_ok;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic               last_col, last_row, out_free;
	logic [EW-1:0]      a_mag, v_mag;
	logic [YW-1:0]      y_val, ymag;
	logic [63:0]        ymag64;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] mul_p;
	logic [ACW-1:0]     p_ext;
	logic [127:0]       s2_term;
	logic               root_start;
	root_rsp_t          root_rsp;
	logic [EW-2:0]      root_val, mag;
	logic               neg;
	logic [31:0]        eig;

	evfe_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	evfe_root #(
		.EW  (EW),
		.S1W (S1W),
		.S2W (S2W)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.s1     (s1_q),
		.s2     (s2_q),
		.rsp    (root_rsp),
		.root   (root_val)
	);

	// dimension in use: 0 acts as 1, above MAX_DIM clamps
	always_comb begin
		if (dim_q == 4'd0) d_used = DCW'(1);
		else if (DCW'(dim_q) > DCW'(MAX_DIM)) d_used = DCW'(MAX_DIM);
		else d_used = DCW'(dim_q);
	end

	assign item.ready = (state_q == ST_IDLE);
	assign in_acc     = item.valid && item.ready;
	assign row_ok     = DCW'(item.row_index) < d_used;
	assign col_ok     = DCW'(item.col_index) < d_used;
	assign in_bad     = item.req_type ? !row_ok : !(row_ok && col_ok);
	assign wr_addr    = AW'(16'(item.row_index) * 16'(MAX_DIM) + 16'(item.col_index));
	assign rd_addr    = AW'(16'(i_q) * 16'(MAX_DIM) + 16'(j_q));
	assign last_col   = (DCW'(j_q) + DCW'(1)) == d_used;
	assign last_row   = (DCW'(i_q) + DCW'(1)) == d_used;
	assign out_free   = !out_valid_q || result.ready;

	assign a_mag  = a_rd_q[EW-1] ? -a_rd_q : a_rd_q;
	assign v_mag  = v_rd_q[EW-1] ? -v_rd_q : v_rd_q;
	assign p_ext  = ACW'(mul_p);
	assign y_val  = acc_q[ACW-1:16];
	assign ymag   = y_val[YW-1] ? -y_val : y_val;
	assign ymag64 = 64'(ymag_q);

	always_comb begin
		case (state_q)
			ST_YHI:  s2_term = 128'(mul_p) << 33;
			ST_YEND: s2_term = 128'(mul_p) << 64;
			default: s2_term = 128'(mul_p);
		endcase
	end

	assign neg = v0nz_q && y0nz_q && (v0neg_q != y0neg_q);
	assign mag = root_rsp.sat ? {(EW-1){1'b1}} : root_val;
	assign eig = neg ? (32'd0 - 32'(mag)) : 32'(mag);

	always_comb begin
		state_d    = state_q;
		mul_a      = '0;
		mul_b      = '0;
		root_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item.valid && item.last_item) begin
					state_d = (err_q || in_bad) ? ST_DONE : ST_RD;
				end
			end
			ST_RD: state_d = ST_MUL;
			ST_MUL: begin
				mul_a   = MUL_W'(a_mag);
				mul_b   = MUL_W'(v_mag);
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (i_q == '0) begin
					mul_a   = MUL_W'(v_mag);
					mul_b   = MUL_W'(v_mag);
					state_d = ST_VACC;
				end else begin
					state_d = last_col ? ST_Y : ST_RD;
				end
			end
			ST_VACC: state_d = last_col ? ST_Y : ST_RD;
			ST_Y:    state_d = ST_YLO;
			ST_YLO: begin
				mul_a   = ymag64[31:0];
				mul_b   = ymag64[31:0];
				state_d = ST_YMID;
			end
			ST_YMID: begin
				mul_a   = ymag64[31:0];
				mul_b   = ymag64[63:32];
				state_d = ST_YHI;
			end
			ST_YHI: begin
				mul_a   = ymag64[63:32];
				mul_b   = ymag64[63:32];
				state_d = ST_YEND;
			end
			ST_YEND: state_d = last_row ? ST_CHK : ST_RD;
			ST_CHK: begin
				if (s1_q == '0) begin
					state_d = ST_DONE;
				end else begin
					root_start = 1'b1;
					state_d    = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dim_q       <= DIM_RESET;
			err_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr[2] == REG_DIMENSION) begin
				dim_q <= pwdata[3:0];
			end
			if (in_acc) begin
				if (item.last_item) begin
					err_q <= 1'b0;
					i_q   <= '0;
					j_q   <= '0;
				end else if (in_bad) begin
					err_q <= 1'b1;
				end
			end
			if ((state_q == ST_ACC || state_q == ST_VACC) && state_d == ST_RD) begin
				j_q <= j_q + IW'(1);
			end
			if (state_q == ST_YEND && !last_row) begin
				i_q <= i_q + IW'(1);
				j_q <= '0;
			end
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !in_bad) begin
			if (item.req_type) vec_mem[IW'(item.row_index)] <= item.entry_value[EW-1:0];
			else mat_mem[wr_addr] <= item.entry_value[EW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && item.last_item) begin
					acc_q        <= '0;
					s1_q         <= '0;
					s2_q         <= '0;
					res_eig_q    <= '0;
					res_status_q <= STATUS_INDEX;
				end
			end
			ST_RD: begin
				a_rd_q <= mat_mem[rd_addr];
				v_rd_q <= vec_mem[j_q];
			end
			ST_MUL: begin
				psign_q <= a_rd_q[EW-1] ^ v_rd_q[EW-1];
				if (i_q == '0 && j_q == '0) begin
					v0neg_q <= v_rd_q[EW-1];
					v0nz_q  <= (v_rd_q != '0);
				end
			end
			ST_ACC:  acc_q <= psign_q ? (acc_q - p_ext) : (acc_q + p_ext);
			ST_VACC: s1_q <= s1_q + S1W'(mul_p);
			ST_Y: begin
				ymag_q <= ymag;
				if (i_q == '0) begin
					y0neg_q <= y_val[YW-1];
					y0nz_q  <= (y_val != '0);
				end
			end
			ST_YMID, ST_YHI: s2_q <= s2_q + S2W'(s2_term);
			ST_YEND: begin
				s2_q  <= s2_q + S2W'(s2_term);
				acc_q <= '0;
			end
			ST_CHK: begin
				if (s1_q == '0) begin
					res_eig_q    <= '0;
					res_status_q <= STATUS_ZERO_VEC;
				end
			end
			ST_ROOT: begin
				if (root_rsp.done) begin
					res_eig_q    <= eig;
					res_status_q <= STATUS_OK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_eig_q    <= res_eig_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid      = out_valid_q;
	assign result.eigenvalue = out_eig_q;
	assign result.status     = out_status_q;

	assign prdata = (paddr[2] == REG_DIMENSION) ? 32'(dim_q) : 32'd0;
	assign pready = 1'b1;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import evfe_pkg::*;

	localparam int MAX_DIM = 8;
	localparam int RANDOM_WORDS = 1100;
	localparam int SETTLE_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_LIMIT = 10;
	localparam logic REQ_MATRIX = 1'b0;
	localparam logic REQ_VECTOR = 1'b1;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
	localparam logic [PADDR_W-1:0] DIM_ADDR = PADDR_W'({REG_DIMENSION, 2'b00});

	typedef struct packed {
		logic        req_type;
		logic [2:0]  row_index;
		logic [2:0]  col_index;
		logic [31:0] entry_value;
		logic        last_item;
	} load_word_t;

	typedef struct packed {
		logic [31:0] eigenvalue;
		status_t     status;
	} estimate_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	evfe_in_if in_bus();
	evfe_out_if out_bus();

	eigenvalue_from_eigenvector dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(in_bus),
		.result(out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic signed [31:0] matrix_copy [0:MAX_DIM-1][0:MAX_DIM-1];
	logic signed [31:0] vector_copy [0:MAX_DIM-1];
	logic index_fault;
	logic [3:0] dim_setting;

	estimate_t pending_estimates[$];
	estimate_t oldest;
	int mismatches;
	int words_sent;
	int cycle_count;
	int result_hold;
	bit steady;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic int eff_dim();
		if (dim_setting == 0)
			return 1;
		if (dim_setting > MAX_DIM)
			return MAX_DIM;
		return int'(dim_setting);
	endfunction

	// store the word, and on the last word work out the estimate
	function automatic void apply_word(input load_word_t w);
		int d;
		int i;
		int j;
		int b;
		logic signed [127:0] acc;
		logic signed [127:0] sq;
		logic signed [127:0] sum_v;
		logic signed [127:0] sum_y;
		logic signed [127:0] y0;
		logic [191:0] num;
		logic [191:0] den;
		logic [191:0] quo;
		logic [63:0] root;
		logic [63:0] trial;
		logic [31:0] mag;
		logic neg;
		estimate_t est;
		d = eff_dim();
		if (w.req_type == REQ_MATRIX) begin
			if (w.row_index < d && w.col_index < d)
				matrix_copy[w.row_index][w.col_index] = w.entry_value;
			else
				index_fault = 1'b1;
		end else begin
			if (w.row_index < d)
				vector_copy[w.row_index] = w.entry_value;
			else
				index_fault = 1'b1;
		end
		if (!w.last_item)
			return;
		est.eigenvalue = 32'h0;
		if (index_fault) begin
			est.status = STATUS_INDEX;
			index_fault = 1'b0;
			pending_estimates.push_back(est);
			return;
		end
		sum_v = 0;
		sum_y = 0;
		y0 = 0;
		for (i = 0; i < d; i++) begin
			acc = 0;
			for (j = 0; j < d; j++)
				acc += matrix_copy[i][j] * vector_copy[j];
			acc = acc >>> 16;
			if (i == 0)
				y0 = acc;
			sq = acc * acc;
			sum_y += sq;
			sq = vector_copy[i] * vector_copy[i];
			sum_v += sq;
		end
		if (sum_v == 0) begin
			est.status = STATUS_ZERO_VEC;
			pending_estimates.push_back(est);
			return;
		end
		num = '0;
		num[159:32] = sum_y;
		den = '0;
		den[127:0] = sum_v;
		quo = num / den;
		if (quo >= (192'd1 << 62)) begin
			mag = 32'h7FFF_FFFF;
		end else begin
			root = 0;
			for (b = 30; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= quo[63:0])
					root = trial;
			end
			mag = root[31:0];
		end
		neg = (vector_copy[0] != 0) && (y0 != 0) && (vector_copy[0][31] != y0[127]);
		est.eigenvalue = neg ? -mag : mag;
		est.status = STATUS_OK;
		pending_estimates.push_back(est);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (pending_estimates.size() == 0) begin
				log_mismatch($sformatf("unexpected word: eigenvalue %h status %0d",
					out_bus.eigenvalue, out_bus.status));
			end else begin
				oldest = pending_estimates.pop_front();
				if (out_bus.status !== oldest.status)
					log_mismatch($sformatf("status: expected %0d, got %0d",
						oldest.status, out_bus.status));
				if (out_bus.eigenvalue !== oldest.eigenvalue)
					log_mismatch($sformatf("eigenvalue: expected %h, got %h",
						oldest.eigenvalue, out_bus.eigenvalue));
			end
		end
	end

	// receiver: random stalls, a counted hold-off, or always ready when steady
	always @(negedge clk) begin
		if (result_hold > 0) begin
			out_bus.ready = 1'b0;
			result_hold--;
		end else if (steady) begin
			out_bus.ready = 1'b1;
		end else begin
			out_bus.ready = ($urandom_range(99) >= 14);
		end
	end

	task automatic send_word(input load_word_t w);
		if (!steady && $urandom_range(99) < 10) begin
			@(negedge clk);
			in_bus.valid = 1'b0;
			repeat ($urandom_range(1)) @(negedge clk);
		end
		@(negedge clk);
		in_bus.req_type = w.req_type;
		in_bus.row_index = w.row_index;
		in_bus.col_index = w.col_index;
		in_bus.entry_value = w.entry_value;
		in_bus.last_item = w.last_item;
		in_bus.valid = 1'b1;
		do @(posedge clk); while (!in_bus.ready);
		apply_word(w);
		words_sent++;
	endtask

	task automatic drain(input bit settle);
		@(negedge clk);
		in_bus.valid = 1'b0;
		while (pending_estimates.size() != 0) @(posedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data,
		output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = DIM_ADDR;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_dimension(input logic [3:0] value);
		logic [31:0] readback;
		drain(1);
		apb_access(1'b1, {28'($urandom()), value}, readback);
		dim_setting = value;
		apb_access(1'b0, 32'h0, readback);
		if (readback[3:0] !== value)
			log_mismatch($sformatf("dimension readback: expected %0d, got %0d",
				value, readback[3:0]));
	endtask

	function automatic load_word_t make_word(input logic req, input int row, input int col,
		input logic [31:0] value, input logic last);
		load_word_t w;
		w.req_type = req;
		w.row_index = row[2:0];
		w.col_index = col[2:0];
		w.entry_value = value;
		w.last_item = last;
		return w;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3, 4: return $urandom();
			default: return 32'($urandom_range(20'hF_FFFF)) - 32'h0008_0000;
		endcase
	endfunction

	// stray picks an index beyond the dimension (only meaningful below MAX_DIM)
	function automatic load_word_t rand_word(input int d, input bit stray);
		load_word_t w;
		w.req_type = $urandom_range(1);
		w.col_index = $urandom_range(7);
		w.last_item = 1'b0;
		w.entry_value = rand_value();
		if (!stray) begin
			w.row_index = $urandom_range(d - 1);
			if (w.req_type == REQ_MATRIX)
				w.col_index = $urandom_range(d - 1);
		end else if (w.req_type == REQ_VECTOR || $urandom_range(1)) begin
			w.row_index = $urandom_range(7, d);
		end else begin
			w.row_index = $urandom_range(d - 1);
			w.col_index = $urandom_range(7, d);
		end
		return w;
	endfunction

	task automatic run_sequence(input int d);
		int n;
		int k;
		bit broken;
		bit zero_vec;
		load_word_t w;
		n = $urandom_range(d * d + d);
		broken = (d < MAX_DIM) && ($urandom_range(99) < 15);
		zero_vec = ($urandom_range(99) < 5);
		if (zero_vec)
			for (k = 0; k < d; k++)
				send_word(make_word(REQ_VECTOR, k, $urandom_range(7), 32'h0, 1'b0));
		for (k = 0; k < n; k++) begin
			w = rand_word(d, (d < MAX_DIM) && ($urandom_range(99) < 3));
			if (zero_vec && w.req_type == REQ_VECTOR)
				w.entry_value = 32'h0;
			send_word(w);
		end
		if (broken)
			send_word(rand_word(d, 1'b1));
		w = rand_word(d, 1'b0);
		if (zero_vec) begin
			w.req_type = REQ_MATRIX;
			w.col_index = $urandom_range(d - 1);
		end
		w.last_item = 1'b1;
		send_word(w);
	endtask

	function automatic logic [3:0] pick_dimension();
		case ($urandom_range(19))
			0, 1, 2, 3: return 4'd1;
			4, 5, 6, 7: return 4'd2;
			8, 9, 10: return 4'd3;
			11, 12: return 4'd4;
			13: return 4'd5;
			14: return 4'd6;
			15: return 4'd7;
			16: return 4'd8;
			17: return 4'd0;
			18: return 4'd15;
			default: return 4'($urandom_range(14, 9));
		endcase
	endfunction

	// writes every entry once so that no later read hits an unwritten one
	task automatic test_full_load();
		int i;
		int j;
		for (i = 0; i < MAX_DIM; i++)
			for (j = 0; j < MAX_DIM; j++)
				send_word(make_word(REQ_MATRIX, i, j, rand_value(), 1'b0));
		for (i = 0; i < MAX_DIM; i++)
			send_word(make_word(REQ_VECTOR, i, $urandom_range(7), rand_value(),
				i == MAX_DIM - 1));
	endtask

	task automatic test_edge_values();
		set_dimension(4'd1);
		send_word(make_word(REQ_MATRIX, 0, 0, 32'h7FFF_FFFF, 1'b0));
		send_word(make_word(REQ_VECTOR, 0, 0, 32'h7FFF_FFFF, 1'b1));
		send_word(make_word(REQ_MATRIX, 0, 0, 32'h8000_0000, 1'b0));
		send_word(make_word(REQ_VECTOR, 0, 0, 32'h8000_0000, 1'b1));
		// opposite signs: negated estimate
		send_word(make_word(REQ_MATRIX, 0, 0, Q_NEG_ONE, 1'b0));
		send_word(make_word(REQ_VECTOR, 0, 0, Q_ONE, 1'b1));
		send_word(make_word(REQ_VECTOR, 0, 0, 32'h0, 1'b1));
		send_word(make_word(REQ_MATRIX, 0, 0, 32'h0, 1'b0));
		send_word(make_word(REQ_VECTOR, 0, 0, Q_ONE, 1'b1));
		// tiny negative product floors to -1 lsb
		send_word(make_word(REQ_MATRIX, 0, 0, 32'h1, 1'b0));
		send_word(make_word(REQ_VECTOR, 0, 0, 32'hFFFF_FFFF, 1'b1));
		set_dimension(4'd2);
		send_word(make_word(REQ_MATRIX, 0, 1, 32'h7FFF_FFFF, 1'b0));
		send_word(make_word(REQ_MATRIX, 1, 0, 32'h8000_0000, 1'b0));
		send_word(make_word(REQ_VECTOR, 1, 0, Q_NEG_ONE, 1'b0));
		send_word(make_word(REQ_VECTOR, 0, 0, Q_ONE, 1'b1));
	endtask

	task automatic test_index_errors();
		send_word(make_word(REQ_MATRIX, 5, 0, Q_ONE, 1'b0));
		send_word(make_word(REQ_VECTOR, 0, 0, Q_ONE, 1'b1));
		// column ignored on vector words; flag cleared by the last result
		send_word(make_word(REQ_VECTOR, 1, 7, Q_ONE, 1'b1));
		send_word(make_word(REQ_MATRIX, 0, 7, Q_ONE, 1'b0));
		send_word(make_word(REQ_VECTOR, 3, 0, Q_ONE, 1'b0));
		send_word(make_word(REQ_MATRIX, 1, 1, Q_ONE, 1'b1));
		send_word(make_word(REQ_VECTOR, 7, 0, Q_ONE, 1'b1));
	endtask

	task automatic test_dimension_clamp();
		set_dimension(4'd0);
		send_word(make_word(REQ_MATRIX, 1, 0, Q_ONE, 1'b0));
		send_word(make_word(REQ_VECTOR, 0, 0, Q_ONE, 1'b1));
		send_word(make_word(REQ_VECTOR, 0, 0, Q_NEG_ONE, 1'b1));
		set_dimension(4'd15);
		send_word(make_word(REQ_MATRIX, 7, 7, Q_NEG_ONE, 1'b1));
	endtask

	task automatic test_backpressure();
		set_dimension(4'd2);
		result_hold = 2500;
		repeat (4) run_sequence(2);
		drain(0);
	endtask

	task automatic test_random();
		int start;
		int phase;
		start = words_sent;
		phase = 0;
		while (words_sent - start < RANDOM_WORDS) begin
			set_dimension(phase == 2 ? 4'd8 : pick_dimension());
			steady = (phase == 2);
			repeat ($urandom_range(8, 3)) begin
				run_sequence(eff_dim());
				if ($urandom_range(99) < 10)
					drain(0);
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_bus.valid = 1'b0;
		in_bus.req_type = REQ_MATRIX;
		in_bus.row_index = '0;
		in_bus.col_index = '0;
		in_bus.entry_value = '0;
		in_bus.last_item = 1'b0;
		out_bus.ready = 1'b0;
		mismatches = 0;
		words_sent = 0;
		cycle_count = 0;
		result_hold = 0;
		steady = 1'b0;
		index_fault = 1'b0;
		dim_setting = DIM_RESET;
		for (int i = 0; i < MAX_DIM; i++) begin
			vector_copy[i] = '0;
			for (int j = 0; j < MAX_DIM; j++)
				matrix_copy[i][j] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_full_load();
		test_edge_values();
		test_index_errors();
		test_dimension_clamp();
		test_backpressure();
		test_random();

		drain(1);
		if (mismatches == 0 && pending_estimates.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
